// ----- sv/cfc_pkg.sv -----
// Shared types, constants and command decoder for the command frame checker.
`default_nettype none

package cfc_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 2048;

  // Largest length for which length+10 still fits the 12-bit byte index
  localparam logic [15:0] LEN_CAP = 16'd4085;

  localparam logic [7:0] HDR_BYTE     = 8'h53;
  localparam logic [11:0] PAYLOAD_POS = 12'd10;
  localparam logic [11:0] POS_LEN_LO  = 12'd6;
  localparam logic [11:0] POS_LEN_HI  = 12'd7;
  localparam logic [11:0] POS_CMD_HI  = 12'd8;
  localparam logic [11:0] POS_CMD_LO  = 12'd9;
  localparam logic [11:0] POS_ID_LAST = 12'd4;

  // Command group bytes (first command byte)
  localparam logic [7:0] GRP_02 = 8'h02;
  localparam logic [7:0] GRP_04 = 8'h04;
  localparam logic [7:0] GRP_09 = 8'h09;
  localparam logic [7:0] GRP_0A = 8'h0A;
  localparam logic [7:0] GRP_0B = 8'h0B;
  localparam logic [7:0] GRP_0C = 8'h0C;
  localparam logic [7:0] GRP_0D = 8'h0D;
  localparam logic [7:0] GRP_11 = 8'h11;
  localparam logic [7:0] GRP_F1 = 8'hF1;

  // Sub-command bytes (second command byte)
  localparam logic [7:0] SUB_00 = 8'h00;
  localparam logic [7:0] SUB_01 = 8'h01;
  localparam logic [7:0] SUB_02 = 8'h02;
  localparam logic [7:0] SUB_03 = 8'h03;
  localparam logic [7:0] SUB_04 = 8'h04;
  localparam logic [7:0] SUB_05 = 8'h05;

  typedef enum logic [1:0] {
    ST_GOOD     = 2'd0,
    ST_CSUM_ERR = 2'd1,
    ST_TOO_LONG = 2'd2
  } frame_status_t;

  typedef enum logic [4:0] {
    CMD_NONE    = 5'd0,
    CMD_02_01   = 5'd1,   // read parameters
    CMD_02_02   = 5'd2,
    CMD_04_03   = 5'd3,
    CMD_04_04   = 5'd4,
    CMD_04_05   = 5'd5,
    CMD_09_01   = 5'd6,
    CMD_09_02   = 5'd7,
    CMD_0A_00   = 5'd8,
    CMD_0A_01   = 5'd9,
    CMD_0A_02   = 5'd10,
    CMD_0B_01   = 5'd11,  // read door
    CMD_0B_02   = 5'd12,
    CMD_0C_01   = 5'd13,
    CMD_0C_02   = 5'd14,
    CMD_0D_01   = 5'd15,
    CMD_0D_02   = 5'd16,
    CMD_11_00   = 5'd17,
    CMD_11_01   = 5'd18,
    CMD_11_02   = 5'd19,
    CMD_F1_01   = 5'd20
  } cmd_code_t;

  // Map a command byte pair to its dense code; unauthenticated frames only
  // get the two read commands.
  function automatic cmd_code_t classify(input logic [7:0] c1, input logic [7:0] c2,
                                         input logic ok);
    cmd_code_t code;
    code = CMD_NONE;
    unique case (c1)
      GRP_02: begin
        if (c2 == SUB_01) code = CMD_02_01;
        else if (c2 == SUB_02) code = CMD_02_02;
      end
      GRP_04: begin
        if (c2 == SUB_03) code = CMD_04_03;
        else if (c2 == SUB_04) code = CMD_04_04;
        else if (c2 == SUB_05) code = CMD_04_05;
      end
      GRP_09: begin
        if (c2 == SUB_01) code = CMD_09_01;
        else if (c2 == SUB_02) code = CMD_09_02;
      end
      GRP_0A: begin
        if (c2 == SUB_00) code = CMD_0A_00;
        else if (c2 == SUB_01) code = CMD_0A_01;
        else if (c2 == SUB_02) code = CMD_0A_02;
      end
      GRP_0B: begin
        if (c2 == SUB_01) code = CMD_0B_01;
        else if (c2 == SUB_02) code = CMD_0B_02;
      end
      GRP_0C: begin
        if (c2 == SUB_01) code = CMD_0C_01;
        else if (c2 == SUB_02) code = CMD_0C_02;
      end
      GRP_0D: begin
        if (c2 == SUB_01) code = CMD_0D_01;
        else if (c2 == SUB_02) code = CMD_0D_02;
      end
      GRP_11: begin
        if (c2 == SUB_00) code = CMD_11_00;
        else if (c2 == SUB_01) code = CMD_11_01;
        else if (c2 == SUB_02) code = CMD_11_02;
      end
      GRP_F1: begin
        if (c2 == SUB_01) code = CMD_F1_01;
      end
      default: code = CMD_NONE;
    endcase
    if (!ok && code != CMD_02_01 && code != CMD_0B_01) code = CMD_NONE;
    return code;
  endfunction

endpackage

`default_nettype wire

// ----- sv/command_frame_checker.sv -----
// Command frame checker: per-byte header/ID check, payload decrypt, XOR checksum.
`default_nettype none

// Streams a request frame one byte per transaction and gives one result
// transaction per byte that falls inside a frame. in_frame_first starts a
// frame (abandoning any frame in progress); bytes outside a frame are
// dropped silently. Byte 0 must be 0x53 and bytes 1..4 must match
// cfg_wdata's device ID; bytes 6/7 are the little-endian payload length L;
// bytes 8/9 are the command pair. Payload bytes 10..L+9 come out XORed with
// the XOR of the four ID bytes. Byte L+10 is the checksum (XOR of raw bytes
// 0..L+9); it carries out_last with status, ID match and command code. A
// length above MAX_PAYLOAD (or above 4085) ends the frame on byte 7 with
// status "too long". Throughput is one byte per clock while out_ready does not
// hold the output register: a byte is held in an input register, then the
// per-byte compare/XOR/counter update is done in one step into the output
// register, and back-pressure from out_ready reaches in_ready through one gate.
// Write cfg_wdata only while no frame bytes are in flight.
module command_frame_checker #(
  parameter int unsigned MAX_PAYLOAD = cfc_pkg::MAX_PAYLOAD_DEF
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_frame_first,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic [11:0] out_byte_index,
  output logic        out_in_payload,
  output logic        out_last,
  output logic [1:0]  out_frame_status,
  output logic        out_id_match,
  output logic [4:0]  out_command_code,
  output logic [11:0] out_payload_length
);

  import cfc_pkg::*;

  localparam logic [16:0] MAX_LEN = 17'(MAX_PAYLOAD);

  // device ID register
  logic [31:0] dev_id_r;

  // input stage
  logic        s1_v_r;
  logic [7:0]  s1_rx_r;
  logic        s1_first_r;

  // frame state
  logic [11:0] pos_r,    pos_nxt;
  logic [15:0] len_r,    len_nxt;
  logic [7:0]  csum_r,   csum_nxt;
  logic        id_ok_r,  id_ok_nxt;
  logic [7:0]  cmd1_r,   cmd1_nxt;
  logic [7:0]  cmd2_r,   cmd2_nxt;
  logic        active_r, active_nxt;

  // result register
  logic        out_v_r;
  logic [7:0]  o_byte_r,  o_byte_nxt;
  logic [11:0] o_idx_r;
  logic        o_pay_r,   o_pay_nxt;
  logic        o_last_r,  o_last_nxt;
  logic [1:0]  o_stat_r,  o_stat_nxt;
  logic        o_idm_r,   o_idm_nxt;
  logic [4:0]  o_code_r,  o_code_nxt;
  logic [11:0] o_plen_r,  o_plen_nxt;

  logic        adv;      // input stage may move into the result register
  logic        go;       // a byte is processed this cycle
  logic        emit;     // processed byte yields a result

  // state as seen by this byte (cleared when it starts a frame)
  logic [11:0] cur_pos;
  logic [15:0] cur_len;
  logic [7:0]  cur_csum;
  logic        cur_id_ok;
  logic [7:0]  cur_cmd1;
  logic [7:0]  cur_cmd2;
  logic        cur_active;

  logic [16:0] pos17, len17;
  logic [7:0]  key;
  logic [7:0]  id_byte;
  logic [1:0]  id_sel;
  logic [15:0] len_hi;
  logic        past_hdr;
  logic        is_ck;
  frame_status_t ck_stat;

  assign adv      = !out_v_r || out_ready;
  assign in_ready = !s1_v_r || adv;
  assign go       = s1_v_r && adv;

  assign key    = dev_id_r[7:0] ^ dev_id_r[15:8] ^ dev_id_r[23:16] ^ dev_id_r[31:24];
  assign id_sel = cur_pos[1:0] - 2'd1;
  assign id_byte = dev_id_r[8*id_sel +: 8];

  always_comb begin
    cur_pos    = s1_first_r ? '0 : pos_r;
    cur_len    = s1_first_r ? '0 : len_r;
    cur_csum   = s1_first_r ? '0 : csum_r;
    cur_id_ok  = s1_first_r ? 1'b0 : id_ok_r;
    cur_cmd1   = s1_first_r ? '0 : cmd1_r;
    cur_cmd2   = s1_first_r ? '0 : cmd2_r;
    cur_active = s1_first_r | active_r;
  end

  assign pos17    = {5'd0, cur_pos};
  assign len17    = {1'b0, cur_len};
  assign past_hdr = cur_pos >= PAYLOAD_POS;
  assign is_ck    = past_hdr && (pos17 == len17 + 17'd10);
  assign len_hi   = {s1_rx_r, cur_len[7:0]};
  assign ck_stat  = (cur_csum == s1_rx_r) ? ST_GOOD : ST_CSUM_ERR;

  // per-byte update
  always_comb begin
    pos_nxt    = pos_r;
    len_nxt    = len_r;
    csum_nxt   = csum_r;
    id_ok_nxt  = id_ok_r;
    cmd1_nxt   = cmd1_r;
    cmd2_nxt   = cmd2_r;
    active_nxt = active_r;
    emit       = 1'b0;

    o_pay_nxt  = past_hdr && (pos17 <= len17 + 17'd9);
    o_byte_nxt = o_pay_nxt ? (s1_rx_r ^ key) : s1_rx_r;
    o_last_nxt = 1'b0;
    o_stat_nxt = ST_GOOD;
    o_idm_nxt  = 1'b0;
    o_code_nxt = CMD_NONE;

    if (go && cur_active) begin
      emit       = 1'b1;
      pos_nxt    = cur_pos + 12'd1;
      len_nxt    = cur_len;
      csum_nxt   = cur_csum;
      id_ok_nxt  = cur_id_ok;
      cmd1_nxt   = cur_cmd1;
      cmd2_nxt   = cur_cmd2;
      active_nxt = 1'b1;
      if (is_ck) begin
        o_last_nxt = 1'b1;
        o_stat_nxt = ck_stat;
        o_idm_nxt  = cur_id_ok;
        o_code_nxt = (ck_stat == ST_GOOD) ? classify(cur_cmd1, cur_cmd2, cur_id_ok)
                                          : CMD_NONE;
        active_nxt = 1'b0;
      end else begin
        csum_nxt = cur_csum ^ s1_rx_r;
        if (cur_pos == '0) begin
          id_ok_nxt = (s1_rx_r == HDR_BYTE);
        end else if (cur_pos <= POS_ID_LAST) begin
          if (s1_rx_r != id_byte) id_ok_nxt = 1'b0;
        end else if (cur_pos == POS_LEN_LO) begin
          len_nxt = {8'd0, s1_rx_r};
        end else if (cur_pos == POS_LEN_HI) begin
          len_nxt = len_hi;
          if ({1'b0, len_hi} > MAX_LEN || len_hi > LEN_CAP) begin
            o_last_nxt = 1'b1;
            o_stat_nxt = ST_TOO_LONG;
            o_idm_nxt  = cur_id_ok;
            active_nxt = 1'b0;
          end
        end else if (cur_pos == POS_CMD_HI) begin
          cmd1_nxt = s1_rx_r;
        end else if (cur_pos == POS_CMD_LO) begin
          cmd2_nxt = s1_rx_r;
        end
      end
    end

    // length reported saturated to the 12-bit field
    o_plen_nxt = (len_nxt > 16'd4095) ? 12'hFFF : len_nxt[11:0];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_id_r <= '0;
      s1_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      pos_r    <= '0;
      len_r    <= '0;
      csum_r   <= '0;
      id_ok_r  <= 1'b0;
      cmd1_r   <= '0;
      cmd2_r   <= '0;
      active_r <= 1'b0;
    end else begin
      if (cfg_we) dev_id_r <= cfg_wdata;
      if (in_valid && in_ready) s1_v_r <= 1'b1;
      else if (adv)             s1_v_r <= 1'b0;
      if (adv) out_v_r <= emit;
      pos_r    <= pos_nxt;
      len_r    <= len_nxt;
      csum_r   <= csum_nxt;
      id_ok_r  <= id_ok_nxt;
      cmd1_r   <= cmd1_nxt;
      cmd2_r   <= cmd2_nxt;
      active_r <= active_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_rx_r    <= in_rx_byte;
      s1_first_r <= in_frame_first;
    end
    if (emit) begin
      o_byte_r <= o_byte_nxt;
      o_idx_r  <= cur_pos;
      o_pay_r  <= o_pay_nxt;
      o_last_r <= o_last_nxt;
      o_stat_r <= o_stat_nxt;
      o_idm_r  <= o_idm_nxt;
      o_code_r <= o_code_nxt;
      o_plen_r <= o_plen_nxt;
    end
  end

  assign out_valid          = out_v_r;
  assign out_byte           = o_byte_r;
  assign out_byte_index     = o_idx_r;
  assign out_in_payload     = o_pay_r;
  assign out_last           = o_last_r;
  assign out_frame_status   = o_stat_r;
  assign out_id_match       = o_idm_r;
  assign out_command_code   = o_code_r;
  assign out_payload_length = o_plen_r;

endmodule

`default_nettype wire
